// File: hw/rtl/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
// Used by every module under hw/rtl; depends on nothing.
package ffsa_pkg;

  localparam int MAP_UNITS_DEF = 1024;
  localparam int LEN_W         = 11;
  localparam int BASE_W        = 10;
  localparam int MSIZE_W       = 11;

  localparam logic [MSIZE_W-1:0] MSIZE_RST = 11'd1024;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    RES_PLACED    = 3'd0,
    RES_COMMITTED = 3'd1,
    RES_NOSPACE   = 3'd2,
    RES_SKIPPED   = 3'd3,
    RES_FREED     = 3'd4
  } res_t;

  typedef enum logic [1:0] {
    U_FREE = 2'b00,
    U_OCC  = 2'b01,
    U_TENT = 2'b10
  } unit_t;

  typedef struct packed {
    req_t               req_type;
    logic [LEN_W-1:0]   segment_length;
    logic [BASE_W-1:0]  free_base;
    logic               last_segment;
  } in_word_t;

  typedef struct packed {
    res_t               status;
    logic [BASE_W-1:0]  base_address;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FREE,
    ST_SCAN,
    ST_MARK,
    ST_SWEEP_INIT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_FREE_INIT,
    DP_FREE,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_MARK_INIT,
    DP_MARK,
    DP_SWEEP_INIT,
    DP_SWEEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take;
    logic   commit;
    logic   out_load;
    res_t   out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic last;
    logic clear_end;
    logic free_end;
    logic found;
    logic scan_end;
    logic mark_last;
    logic sweep_end;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/ffsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on ffsa_pkg for its default sizes.
module ffsa_ram import ffsa_pkg::*; #(
  parameter int WIDTH = $bits(unit_t),
  parameter int DEPTH = MAP_UNITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ffsa_dp.sv
// Datapath: unit map RAM, address and run counters, size register, result register.
// Depends on ffsa_pkg and ffsa_ram; driven by ffsa_ctrl through dp_cmd_t.
module ffsa_dp import ffsa_pkg::*; #(
  parameter int MAP_UNITS = MAP_UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MSIZE_W-1:0] cfg_wdata,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts
);

  localparam int AW = $clog2(MAP_UNITS);
  localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [CW-1:0] UNITS     = CW'(MAP_UNITS);
  localparam logic [CW-1:0] LAST_UNIT = CW'(MAP_UNITS - 1);

  logic [MSIZE_W-1:0] msize;
  in_word_t           req;
  logic [CW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      run, run_next;
  logic               rd_vld, rd_vld_next;
  logic [AW-1:0]      rd_addr, rd_addr_next;
  logic [AW-1:0]      base, base_next;

  logic               we;
  logic [AW-1:0]      waddr;
  unit_t              wdata;
  logic [AW-1:0]      raddr;
  logic [1:0]         rdata;

  logic [CW-1:0]      limit;
  logic [CW-1:0]      len;
  logic [CW-1:0]      run_inc;
  logic [CW-1:0]      base_calc;
  logic               rd_free, rd_tent;
  logic               scan_issue, sweep_issue;
  logic               placed;

  ffsa_ram #(
    .WIDTH($bits(unit_t)),
    .DEPTH(MAP_UNITS)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign limit       = (CW'(msize) < UNITS) ? CW'(msize) : UNITS;
  assign len         = CW'(req.segment_length);
  assign run_inc     = run + CW'(1);
  assign base_calc   = CW'(rd_addr) + CW'(1) - len;
  assign rd_free     = rd_vld && (rdata == U_FREE);
  assign rd_tent     = rd_vld && (rdata == U_TENT);
  assign scan_issue  = ptr < limit;
  assign sweep_issue = ptr < UNITS;
  assign placed      = (cmd.out_status == RES_PLACED) || (cmd.out_status == RES_COMMITTED);

  assign sts.is_free   = req.req_type == REQ_FREE;
  assign sts.last      = req.last_segment;
  assign sts.clear_end = ptr == LAST_UNIT;
  assign sts.free_end  = (cnt == '0) || !sweep_issue;
  assign sts.found     = rd_free && (run_inc == len);
  assign sts.scan_end  = !rd_vld && !scan_issue;
  assign sts.mark_last = cnt == CW'(1);
  assign sts.sweep_end = !rd_vld && !sweep_issue;
  assign sts.out_free  = !out_valid || !out_stall;

  always_comb begin
    ptr_next     = ptr;
    cnt_next     = cnt;
    run_next     = run;
    rd_vld_next  = 1'b0;
    rd_addr_next = rd_addr;
    base_next    = base;
    we           = 1'b0;
    waddr        = ptr[AW-1:0];
    wdata        = U_FREE;
    raddr        = ptr[AW-1:0];
    unique case (cmd.op)
      DP_CLEAR: begin
        we       = 1'b1;
        ptr_next = ptr + CW'(1);
      end
      DP_FREE_INIT: begin
        ptr_next = CW'(req.free_base);
        cnt_next = len;
      end
      DP_FREE: begin
        if (!sts.free_end) begin
          we       = 1'b1;
          ptr_next = ptr + CW'(1);
          cnt_next = cnt - CW'(1);
        end
      end
      DP_SCAN_INIT, DP_SWEEP_INIT: begin
        ptr_next = '0;
        run_next = '0;
      end
      DP_SCAN: begin
        if (rd_vld) begin
          run_next = rd_free ? run_inc : '0;
        end
        if (scan_issue) begin
          rd_vld_next  = 1'b1;
          rd_addr_next = ptr[AW-1:0];
          ptr_next     = ptr + CW'(1);
        end
      end
      DP_MARK_INIT: begin
        ptr_next  = base_calc;
        cnt_next  = len;
        base_next = base_calc[AW-1:0];
      end
      DP_MARK: begin
        we       = 1'b1;
        wdata    = U_TENT;
        ptr_next = ptr + CW'(1);
        cnt_next = cnt - CW'(1);
      end
      DP_SWEEP: begin
        if (rd_tent) begin
          we    = 1'b1;
          waddr = rd_addr;
          wdata = cmd.commit ? U_OCC : U_FREE;
        end
        if (sweep_issue) begin
          rd_vld_next  = 1'b1;
          rd_addr_next = ptr[AW-1:0];
          ptr_next     = ptr + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msize  <= MSIZE_RST;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        msize <= cfg_wdata;
      end
      ptr    <= ptr_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    run     <= run_next;
    rd_addr <= rd_addr_next;
    base    <= base_next;
    if (cmd.take) begin
      req <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.status       <= cmd.out_status;
      out_word.base_address <= placed ? BASE_W'(CW'(base)) : '0;
    end
  end

  a_mark_in_map: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_MARK) |-> (ptr < limit))
    else $error("mark pointer outside searched map");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SCAN) |-> (run <= limit))
    else $error("free run longer than map");

  a_base_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(out_word.status == RES_PLACED || out_word.status == RES_COMMITTED))
      |-> (out_word.base_address == '0))
    else $error("nonzero base on unplaced result");

endmodule

// File: hw/rtl/ffsa_ctrl.sv
// Controller state machine: sequences clear, free, scan, mark and sweep phases.
// Depends on ffsa_pkg; commands ffsa_dp through dp_cmd_t, reads dp_sts_t.
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;
  logic   failed, failed_next;
  logic   commit, commit_next;
  res_t   res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      failed     <= 1'b0;
      commit     <= 1'b0;
      res_status <= RES_PLACED;
    end else begin
      state      <= state_next;
      failed     <= failed_next;
      commit     <= commit_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    failed_next     = failed;
    commit_next     = commit;
    res_status_next = res_status;
    cmd             = '0;
    cmd.op          = DP_NOP;
    cmd.commit      = commit;
    cmd.out_status  = res_status;
    in_stall        = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (sts.clear_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_free) begin
          cmd.op     = DP_FREE_INIT;
          state_next = ST_FREE;
        end else if (failed) begin
          res_status_next = RES_SKIPPED;
          if (sts.last) begin
            failed_next = 1'b0;
          end
          state_next = ST_DONE;
        end else begin
          cmd.op     = DP_SCAN_INIT;
          state_next = ST_SCAN;
        end
      end
      ST_FREE: begin
        cmd.op = DP_FREE;
        if (sts.free_end) begin
          res_status_next = RES_FREED;
          state_next      = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.found) begin
          cmd.op     = DP_MARK_INIT;
          state_next = ST_MARK;
        end else if (sts.scan_end) begin
          commit_next     = 1'b0;
          res_status_next = RES_NOSPACE;
          failed_next     = !sts.last;
          state_next      = ST_SWEEP_INIT;
        end else begin
          cmd.op = DP_SCAN;
        end
      end
      ST_MARK: begin
        cmd.op = DP_MARK;
        if (sts.mark_last) begin
          if (sts.last) begin
            commit_next     = 1'b1;
            res_status_next = RES_COMMITTED;
            state_next      = ST_SWEEP_INIT;
          end else begin
            res_status_next = RES_PLACED;
            state_next      = ST_DONE;
          end
        end
      end
      ST_SWEEP_INIT: begin
        cmd.op     = DP_SWEEP_INIT;
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.op = DP_SWEEP;
        if (sts.sweep_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_fail_on_nospace: assert property (@(posedge clk) disable iff (rst)
    $rose(failed) |-> (state == ST_SWEEP_INIT && res_status == RES_NOSPACE))
    else $error("process failure flagged without a no-space result");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && commit) |-> (res_status == RES_COMMITTED))
    else $error("commit sweep without committed result");

endmodule

// File: hw/rtl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: controller plus datapath.
// Depends on ffsa_pkg, ffsa_ctrl, ffsa_dp (which holds the ffsa_ram map).
//
//   channel | handshake            | word        | direction
//   --------+----------------------+-------------+----------
//   cfg     | cfg_we               | cfg_wdata   | in
//   in      | in_valid / in_stall  | in_word     | in
//   out     | out_valid / out_stall| out_word    | out
//
// One word at a time: a free clears the units from free_base up to length or the map end;
// an allocate scans the map up to min(memory_size, MAP_UNITS) for the first free run and
// marks it tentative, then on a commit or a no-space rollback sweeps the whole map;
// an allocate after a failed segment of the same process is skipped.
// The scan and sweep walk the map RAM one unit per cycle through its single read port.
// After rst a clearing pass writes every map unit free, with in_stall high.
// A waiting result in the output register does not block the next input word.
module first_fit_segment_allocator import ffsa_pkg::*; #(
  parameter int MAP_UNITS = MAP_UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MSIZE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  ffsa_dp #(
    .MAP_UNITS(MAP_UNITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_segment_allocator: drives allocate and free words,
// predicts each result from a local copy of the occupancy maps and checks it.
// Depends on ffsa_pkg and the allocator RTL only.
module tb;
  import ffsa_pkg::*;

  localparam int UNITS          = MAP_UNITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  class alloc_scoreboard;
    bit               occupied [UNITS];
    bit               tentative[UNITS];
    bit               proc_failed;
    logic [MSIZE_W-1:0] size_reg;
    out_word_t        expected_q[$];
    int unsigned      proc_base[$];
    int unsigned      proc_len[$];
    int unsigned      live_base[$];
    int unsigned      live_len[$];
    int               errors;

    function new();
      foreach (occupied[i]) begin
        occupied[i]  = 1'b0;
        tentative[i] = 1'b0;
      end
      proc_failed = 1'b0;
      size_reg    = MSIZE_RST;
      errors      = 0;
    endfunction

    function void set_size(logic [MSIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_live();
      live_base.delete();
      live_len.delete();
    endfunction

    function bit pop_live(output int unsigned b, output int unsigned l);
      int idx;
      if (live_base.size() == 0) return 1'b0;
      idx = $urandom_range(0, live_base.size() - 1);
      b   = live_base[idx];
      l   = live_len[idx];
      live_base.delete(idx);
      live_len.delete(idx);
      return 1'b1;
    endfunction

    function bit lowest_run(int unsigned len, output int unsigned b);
      int unsigned span, run, i;
      span = (size_reg < UNITS) ? size_reg : UNITS;
      run  = 0;
      b    = 0;
      if (len == 0) return 1'b0;
      for (i = 0; i < span; i++) begin
        if (occupied[i] || tentative[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == len) begin
            b = i + 1 - len;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_input(in_word_t w);
      out_word_t   e;
      int unsigned len, b, u, i;
      len            = 32'(w.segment_length);
      b              = 0;
      e.status       = RES_FREED;
      e.base_address = '0;
      if (w.req_type == REQ_FREE) begin
        for (i = 0; i < len; i++) begin
          u = w.free_base + i;
          if (u >= UNITS) break;
          occupied[u]  = 1'b0;
          tentative[u] = 1'b0;
        end
      end else if (proc_failed) begin
        e.status = RES_SKIPPED;
        if (w.last_segment) proc_failed = 1'b0;
      end else if (lowest_run(len, b)) begin
        for (i = 0; i < len; i++) tentative[b + i] = 1'b1;
        proc_base.push_back(b);
        proc_len.push_back(len);
        e.base_address = BASE_W'(b);
        if (w.last_segment) begin
          foreach (tentative[k]) begin
            if (tentative[k]) begin
              occupied[k]  = 1'b1;
              tentative[k] = 1'b0;
            end
          end
          live_base = {live_base, proc_base};
          live_len  = {live_len, proc_len};
          proc_base.delete();
          proc_len.delete();
          e.status = RES_COMMITTED;
        end else begin
          e.status = RES_PLACED;
        end
      end else begin
        foreach (tentative[k]) tentative[k] = 1'b0;
        proc_base.delete();
        proc_len.delete();
        e.status = RES_NOSPACE;
        if (!w.last_segment) proc_failed = 1'b1;
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_word_t r);
      out_word_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d base %0d",
                                  r.status, r.base_address));
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", r.status, e.status));
      if (r.base_address !== e.base_address)
        report_mismatch($sformatf("base_address %0d, expected %0d",
                                  r.base_address, e.base_address));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [MSIZE_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_word;
  logic               out_valid;
  logic               out_stall;
  out_word_t          out_word;

  alloc_scoreboard sb;
  int              idle_pct;
  int              stall_pct;
  int              stall_left;
  int              stuck_cycles;

  first_fit_segment_allocator #(
    .MAP_UNITS(UNITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hold the result channel in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_word);
      if (in_valid && !in_stall) sb.note_input(in_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  function automatic in_word_t make_word(req_t t, int unsigned len, int unsigned fb, bit last);
    in_word_t w;
    w.req_type       = t;
    w.segment_length = LEN_W'(len);
    w.free_base      = BASE_W'(fb);
    w.last_segment   = last;
    return w;
  endfunction

  function automatic in_word_t noise_word();
    return make_word(req_t'($urandom_range(0, 1)), $urandom_range(0, 2047),
                     $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_size(input logic [MSIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_size(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [MSIZE_W-1:0] size, input int n_items,
                           input int idle, input int stall, input bit hold_mid);
    int          sent, nseg, span, maxlen, pick, s;
    int unsigned len, fb, fl;
    bit          held, last;
    wait_drain();
    repeat (UNITS + 8) @(posedge clk);
    write_size(size);
    idle_pct  = idle;
    stall_pct = stall;
    span      = (size < UNITS) ? size : UNITS;
    maxlen    = span / 8 + 1;
    sb.clear_live();
    send_word(make_word(REQ_FREE, UNITS, 0, 1'($urandom_range(0, 1))));
    sent = 1;
    held = 1'b0;
    while (sent < n_items) begin
      // hold off the sender until every result is back
      if (hold_mid && !held && sent >= n_items / 2) begin
        wait_drain();
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30 && sb.pop_live(fb, fl)) begin
        send_word(make_word(REQ_FREE, fl, fb, 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 40) begin
        send_word(noise_word());
        sent++;
      end else begin
        nseg = $urandom_range(1, 4);
        for (s = 0; s < nseg; s++) begin
          len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, maxlen);
          last = (s == nseg - 1) && ($urandom_range(0, 29) != 0);
          send_word(make_word(REQ_ALLOC, len, $urandom_range(0, 1023), last));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_word_t directed_q[$];
    sb        = new();
    idle_pct  = 20;
    stall_pct = 20;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_q.push_back(make_word(REQ_ALLOC, 4, 0, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 8, 1023, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 0, 0, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 2047, 0, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 10, 0, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 1013, 0, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 5, 0, 1'b0));
    directed_q.push_back(make_word(REQ_FREE, 4, 0, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 5, 0, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 1012, 0, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 4, 0, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 1, 0, 1'b1));
    directed_q.push_back(make_word(REQ_FREE, 2047, 1023, 1'b1));
    directed_q.push_back(make_word(REQ_ALLOC, 1, 0, 1'b1));
    directed_q.push_back(make_word(REQ_FREE, 1024, 0, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 1024, 0, 1'b1));
    directed_q.push_back(make_word(REQ_FREE, 2047, 512, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 1, 0, 1'b0));
    directed_q.push_back(make_word(REQ_FREE, 1, 512, 1'b0));
    directed_q.push_back(make_word(REQ_ALLOC, 1, 0, 1'b1));
    directed_q.push_back(make_word(REQ_FREE, 0, 5, 1'b1));
    directed_q.push_back(make_word(REQ_FREE, 1024, 0, 1'b0));
    foreach (directed_q[i]) send_word(directed_q[i]);

    run_phase(11'd1,    40,  25, 25, 1'b0);
    run_phase(11'd0,    20,  10, 40, 1'b0);
    run_phase(11'd2047, 80,  30, 10, 1'b0);
    run_phase(11'd64,   120, 15, 30, 1'b1);
    run_phase(11'd37,   100, 40, 40, 1'b0);
    run_phase(11'd513,  100, 10, 10, 1'b0);
    run_phase(11'd1024, 120, 0,  0,  1'b0);

    wait_drain();
    repeat (2 * UNITS + 16) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/ffsa_dp.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/first_fit_segment_allocator.sv
tb/tb.sv
